// ===== rtl/core/stt_pkg.sv =====
package stt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 32;
  localparam int NUM_SLOTS  = 16;
  localparam int ID_W       = 4;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_ADJUST = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_TICK   = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_ABSENT = 2'd2;
  localparam logic [1:0] STAT_DUP    = 2'd3;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  typedef logic [TIME_BITS-1:0] expiry_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  timer_id;
    logic [31:0] expire_time;
    logic [31:0] now;
  } stt_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       expired_valid;
    logic [3:0] expired_id;
    logic       last;
  } stt_out_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] id;
    expiry_t         expiry;
  } stt_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    expiry_t         expiry;
    logic            le;
    logic            hit;
  } stt_link_t;

endpackage

// ===== rtl/core/stt_cell.sv =====
module stt_cell import stt_pkg::*; (
  input  logic      clk,
  input  stt_cmd_t  cmd,
  input  logic      occ,
  input  stt_link_t from_left,
  input  stt_link_t from_right,
  output stt_link_t link
);

  logic [ID_W-1:0] id_r, id_nxt;
  expiry_t         exp_r, exp_nxt;
  logic            le;
  logic            hit;

  assign le  = occ && (exp_r <= cmd.expiry);
  assign hit = (cmd.op == OP_POP) || from_left.hit || (occ && (id_r == cmd.id));

  always_comb begin
    id_nxt  = id_r;
    exp_nxt = exp_r;
    case (cmd.op)
      OP_INSERT: begin
        if (!le) begin
          if (from_left.le) begin
            id_nxt  = cmd.id;
            exp_nxt = cmd.expiry;
          end else begin
            id_nxt  = from_left.id;
            exp_nxt = from_left.expiry;
          end
        end
      end
      OP_REMOVE, OP_POP: begin
        if (hit) begin
          id_nxt  = from_right.id;
          exp_nxt = from_right.expiry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    exp_r <= exp_nxt;
  end

  assign link.id     = id_r;
  assign link.expiry = exp_r;
  assign link.le     = le;
  assign link.hit    = hit;

endmodule

// ===== rtl/core/sorted_expiry_timer_table.sv =====
// Add and delete put their result in the output register in the cycle after the request is taken.
// Adjust of a present timer first pulls it out of the chain, then inserts it again in S_INS.
// Tick latches the time when the request is taken, then in S_TICK gives one result per expired timer,
// or a single result when none expired, each waiting for a free output register.
// A new request is taken once the previous one is finished and the output register is free.
// Reset clears the state, the presence bits, the timer count and the output valid flag; the list cells are not cleared.
module sorted_expiry_timer_table import stt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  stt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output stt_out_t out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [NUM_SLOTS-1:0] slot_r, slot_nxt;
  logic [ID_W-1:0]      key_id_r, key_id_nxt;
  expiry_t              key_time_r, key_time_nxt;
  logic                 out_valid_r, out_valid_nxt;
  stt_out_t             out_r, out_nxt;

  stt_cmd_t             cmd;
  stt_link_t            links [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] occ;
  logic                 accept;
  logic                 head_due;
  logic                 next_due;
  logic                 out_free;

  stt_link_t edge_link;
  assign edge_link = '{id: '0, expiry: '0, le: 1'b1, hit: 1'b0};

  genvar g;
  generate
    for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
      stt_link_t left_in, right_in;
      assign occ[g] = (count_r > CNT_W'(g));
      if (g == 0) begin : g_first
        assign left_in = edge_link;
      end else begin : g_mid
        assign left_in = links[g-1];
      end
      if (g == NUM_TIMERS - 1) begin : g_end
        assign right_in = links[g];
      end else begin : g_inner
        assign right_in = links[g+1];
      end
      stt_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occ        (occ[g]),
        .from_left  (left_in),
        .from_right (right_in),
        .link       (links[g])
      );
    end
  endgenerate

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign head_due = (count_r != '0) && (links[0].expiry <= key_time_r);
  assign next_due = (count_r > CNT_W'(1)) && (links[1].expiry <= key_time_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    slot_nxt      = slot_r;
    key_id_nxt    = key_id_r;
    key_time_nxt  = key_time_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    cmd.op        = OP_HOLD;
    cmd.id        = (state_r == S_IDLE) ? in_data.timer_id : key_id_r;
    cmd.expiry    = (state_r == S_IDLE) ? TIME_BITS'(in_data.expire_time) : key_time_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_id_nxt    = in_data.timer_id;
          key_time_nxt  = (in_data.action == ACT_TICK) ? TIME_BITS'(in_data.now)
                                                       : TIME_BITS'(in_data.expire_time);
          out_nxt       = '{status: STAT_OK, expired_valid: 1'b0, expired_id: '0, last: 1'b1};
          case (in_data.action)
            ACT_ADD: begin
              out_valid_nxt = 1'b1;
              if (slot_r[in_data.timer_id]) begin
                out_nxt.status = STAT_DUP;
              end else if (count_r >= CNT_W'(NUM_TIMERS)) begin
                out_nxt.status = STAT_FULL;
              end else begin
                cmd.op                     = OP_INSERT;
                count_nxt                  = count_r + CNT_W'(1);
                slot_nxt[in_data.timer_id] = 1'b1;
              end
            end
            ACT_ADJUST, ACT_DELETE: begin
              if (!slot_r[in_data.timer_id]) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = STAT_ABSENT;
              end else begin
                cmd.op    = OP_REMOVE;
                count_nxt = count_r - CNT_W'(1);
                if (in_data.action == ACT_DELETE) begin
                  slot_nxt[in_data.timer_id] = 1'b0;
                  out_valid_nxt              = 1'b1;
                end else begin
                  state_nxt = S_INS;
                end
              end
            end
            default: begin
              state_nxt = S_TICK;
            end
          endcase
        end
      end
      S_INS: begin
        cmd.op        = OP_INSERT;
        count_nxt     = count_r + CNT_W'(1);
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: STAT_OK, expired_valid: 1'b0, expired_id: '0, last: 1'b1};
        state_nxt     = S_IDLE;
      end
      S_TICK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (head_due) begin
            cmd.op                 = OP_POP;
            count_nxt              = count_r - CNT_W'(1);
            slot_nxt[links[0].id]  = 1'b0;
            out_nxt = '{status: STAT_OK, expired_valid: 1'b1, expired_id: links[0].id,
                        last: !next_due};
            if (!next_due) begin
              state_nxt = S_IDLE;
            end
          end else begin
            out_nxt   = '{status: STAT_OK, expired_valid: 1'b0, expired_id: '0, last: 1'b1};
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_id_r   <= key_id_nxt;
    key_time_r <= key_time_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NUM_TIMERS))
    else $error("timer count exceeds table size");

  a_presence_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_r) == int'(count_r) || state_r == S_INS)
    else $error("presence bits disagree with timer count");

  a_ins_output_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |-> !out_valid_r)
    else $error("output busy during reinsertion");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK && out_free && head_due) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("expiry did not remove a timer");

endmodule
